FILE: rtl/core/crcw_pkg.sv
// ----------------------------------------------------------------------------
// crcw_pkg
// Shared types and constants for the word-style byte-stream CRC-32 unit:
// beat structs and the column table of the 32-step polynomial shift.
// ----------------------------------------------------------------------------
package crcw_pkg;

	localparam int unsigned CRC_W     = 32;
	localparam int unsigned BYTE_W    = 8;
	localparam logic [CRC_W-1:0] CRC_POLY     = 32'h04C1_1DB7;
	localparam logic [CRC_W-1:0] CRC_TOP_BIT  = 32'h8000_0000;
	localparam logic [CRC_W-1:0] CRC_ALL_ONES = 32'hFFFF_FFFF;

	// input beat
	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              start_req;
		logic              last_byte;
	} in_beat_t;

	// result beat
	typedef struct packed {
		logic [CRC_W-1:0] crc;
		logic             is_final;
	} out_beat_t;

	typedef logic [CRC_W-1:0] crc_cols_t [CRC_W];

	// image of each unit vector after 32 shift steps; evaluated on constants only
	function automatic crc_cols_t crc_gen_cols();
		crc_cols_t cols;
		logic [CRC_W-1:0] v;
		for (int i = 0; i < CRC_W; i++) begin
			v = CRC_W'(1) << i;
			for (int k = 0; k < CRC_W; k++) begin
				if ((v & CRC_TOP_BIT) != '0) begin
					v = (v << 1) ^ CRC_POLY;
				end else begin
					v = v << 1;
				end
			end
			cols[i] = v;
		end
		return cols;
	endfunction

	localparam crc_cols_t CRC_COLS = crc_gen_cols();

endpackage

FILE: rtl/core/crcw_calc.sv
// ----------------------------------------------------------------------------
// crcw_calc
// Combinational CRC update: picks the base value, folds in the byte and
// applies the 32-step shift as one flat xor network over table columns.
// ----------------------------------------------------------------------------
module crcw_calc
(
	input  crcw_pkg::in_beat_t          beat,
	input  logic [crcw_pkg::CRC_W-1:0]  init_value,
	input  logic [crcw_pkg::CRC_W-1:0]  running_crc,
	output logic [crcw_pkg::CRC_W-1:0]  crc
);
	import crcw_pkg::*;

	logic [CRC_W-1:0] base;
	logic [CRC_W-1:0] word;

	// base select and byte fold
	always_comb begin
		base = beat.start_req ? init_value : running_crc;
		word = base ^ CRC_W'(beat.data_byte);
	end

	// linear map: xor of the columns picked by the set bits
	always_comb begin
		crc = '0;
		for (int i = 0; i < CRC_W; i++) begin
			if (word[i]) begin
				crc = crc ^ CRC_COLS[i];
			end
		end
	end

endmodule

FILE: rtl/core/crc32_word_style_byte_stream_unit.sv
// ----------------------------------------------------------------------------
// crc32_word_style_byte_stream_unit
// Running CRC-32 (poly 04C11DB7, msb first, no reflection, no final xor)
// over a byte stream, each byte absorbed as a zero-extended 32-bit word.
// ----------------------------------------------------------------------------
// usage:
//   in  channel: one byte per beat with start_req (reload init value first)
//       and last_byte (echoed back as is_final)
//   out channel: one beat per input beat carrying the updated crc
//   cfg channel: writes init_value, always ready; the new value is used by
//       later start requests only and leaves the running crc untouched
// path: input accept loads the input register, then the xor network feeds
//   the result register, whose output is the result beat
// throughput: one byte per cycle while out_ready stays high; the running crc
//   is updated as a beat moves from the input register to the result
//   register, so consecutive beats chain without bubbles
// reset: init value and running crc become all ones, both stages empty
// stall: while out_ready is low the result register holds; the input
//   register still takes one more beat, then in_ready drops until the
//   result is taken
// ----------------------------------------------------------------------------
module crc32_word_style_byte_stream_unit
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  crcw_pkg::in_beat_t          in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output crcw_pkg::out_beat_t         out_data,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [crcw_pkg::CRC_W-1:0]  cfg_data
);
	import crcw_pkg::*;

	in_beat_t         in_s1;
	logic             vld_s1;
	out_beat_t        out_s2;
	logic             vld_s2;
	logic [CRC_W-1:0] init_value_q;
	logic [CRC_W-1:0] running_crc_q;
	logic [CRC_W-1:0] crc_next;
	logic             load_s2;
	logic             adv_s1;
	logic             load_s1;

	// handshake control
	always_comb begin
		load_s2   = !vld_s2 || out_ready;
		adv_s1    = vld_s1 && load_s2;
		in_ready  = !vld_s1 || load_s2;
		load_s1   = in_valid && in_ready;
		cfg_ready = 1'b1;
	end

	// crc update network
	crcw_calc u_calc (
		.beat        (in_s1),
		.init_value  (init_value_q),
		.running_crc (running_crc_q),
		.crc         (crc_next)
	);

	// config register and running crc
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_value_q  <= CRC_ALL_ONES;
			running_crc_q <= CRC_ALL_ONES;
		end else begin
			if (cfg_valid && cfg_ready) begin
				init_value_q <= cfg_data;
			end
			if (adv_s1) begin
				running_crc_q <= crc_next;
			end
		end
	end

	// stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				vld_s1 <= in_valid;
			end
			if (load_s2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (load_s1) begin
			in_s1 <= in_data;
		end
		if (adv_s1) begin
			out_s2.crc      <= crc_next;
			out_s2.is_final <= in_s1.last_byte;
		end
	end

	assign out_valid = vld_s2;
	assign out_data  = out_s2;

endmodule
